### hw/rtl/swsh_pkg.sv
// ----------------------------------------------------------------------------
// swsh_pkg
// Shared widths and stage records for the spectral Wiener shrink pipeline.
// ----------------------------------------------------------------------------
package swsh_pkg;

    localparam int COMP_W    = 16;  // signed bin component
    localparam int POW_W     = 32;  // re^2 + im^2, up to 2^31
    localparam int SQ_W      = 31;  // one square, up to 2^30
    localparam int GAIN_W    = 17;  // unsigned Q16 gain, 65536 is one
    localparam int DIV_STEPS = 16;  // quotient bits after the leading one
    localparam int FRAC_W    = 16;  // fraction bits of the gain

    // Bin data that rides along the pipeline untouched.
    typedef struct packed {
        logic signed [COMP_W-1:0] re;
        logic signed [COMP_W-1:0] im;
        logic                     last;
    } swsh_bin_t;

    // Partial state of the restoring divider.
    typedef struct packed {
        logic [POW_W-1:0]  rem;
        logic [POW_W-1:0]  divisor;
        logic [GAIN_W-1:0] quot;
    } swsh_div_t;

endpackage

### hw/rtl/spectral_wiener_shrink.sv
// ----------------------------------------------------------------------------
// spectral_wiener_shrink
// Wiener-style shrinkage of one complex frequency bin per item.
// ----------------------------------------------------------------------------
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+-------------------------------------------
//  input   | in_valid  | in_stall  | real_part, imag_part, noise_power, last_bin
//  output  | out_valid | out_stall | out_real, out_imag, shrink_gain, out_last
//
//  One item enters per cycle unless the output stalls. The pipeline holds three
//  stages for square, sum and noise subtract, sixteen restoring-divider steps
//  and one scale stage. The divider sets the depth, one quotient bit per stage.
//  rst_n clears all valid bits asynchronously; payload registers are not reset.
//  A stalled result freezes the whole pipeline and raises in_stall in the same
//  cycle; nothing is dropped or repeated, and flow resumes at full rate.
//
// Gain = floor((power - noise_power) * 65536 / power), zero when power is zero
// or noise reaches power. Each component is multiplied by the gain and shifted
// right arithmetically by 16.
// ----------------------------------------------------------------------------
module spectral_wiener_shrink (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [swsh_pkg::COMP_W-1:0] real_part,
    input  logic signed [swsh_pkg::COMP_W-1:0] imag_part,
    input  logic [swsh_pkg::POW_W-1:0]         noise_power,
    input  logic                               last_bin,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [swsh_pkg::COMP_W-1:0] out_real,
    output logic signed [swsh_pkg::COMP_W-1:0] out_imag,
    output logic [swsh_pkg::GAIN_W-1:0]        shrink_gain,
    output logic                               out_last
);

    logic                advance;
    swsh_pkg::swsh_bin_t bin_in;

    // Divider chain: index 0 is the seed from the power stages, index
    // DIV_STEPS holds the finished quotient.
    logic                valid_chain [0:swsh_pkg::DIV_STEPS];
    swsh_pkg::swsh_bin_t bin_chain   [0:swsh_pkg::DIV_STEPS];
    swsh_pkg::swsh_div_t div_chain   [0:swsh_pkg::DIV_STEPS];

    // Advance everything unless a finished item sits unclaimed at the output.
    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    assign bin_in.re   = real_part;
    assign bin_in.im   = imag_part;
    assign bin_in.last = last_bin;

    swsh_power u_power (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .valid_in  (in_valid),
        .bin_in    (bin_in),
        .sigma_in  (noise_power),
        .valid_out (valid_chain[0]),
        .bin_out   (bin_chain[0]),
        .div_out   (div_chain[0])
    );

    for (genvar i = 0; i < swsh_pkg::DIV_STEPS; i++)
    begin : g_div
        swsh_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (valid_chain[i]),
            .bin_in    (bin_chain[i]),
            .div_in    (div_chain[i]),
            .valid_out (valid_chain[i+1]),
            .bin_out   (bin_chain[i+1]),
            .div_out   (div_chain[i+1])
        );
    end

    swsh_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .valid_in  (valid_chain[swsh_pkg::DIV_STEPS]),
        .bin_in    (bin_chain[swsh_pkg::DIV_STEPS]),
        .gain_in   (div_chain[swsh_pkg::DIV_STEPS].quot),
        .valid_out (out_valid),
        .out_re    (out_real),
        .out_im    (out_imag),
        .out_gain  (shrink_gain),
        .out_lst   (out_last)
    );

`ifndef NO_ASSERTIONS
    // The quotient never exceeds unity gain.
    a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (shrink_gain <= 17'd65536))
        else $error("shrink gain above one");

    // A zero gain must silence both components.
    a_zero_gain: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (shrink_gain == '0)) |-> ((out_real == '0) && (out_imag == '0)))
        else $error("zero gain with nonzero output");

    // A frozen pipeline keeps the divider's finished quotient in place.
    a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!advance && valid_chain[swsh_pkg::DIV_STEPS])
            |=> $stable(div_chain[swsh_pkg::DIV_STEPS].quot))
        else $error("divider output moved while stalled");
`endif

endmodule

### hw/rtl/swsh_power.sv
// ----------------------------------------------------------------------------
// swsh_power
// Square, sum and noise subtract: three stages that seed the divider with the
// leading quotient bit, the first remainder and the divisor.
// ----------------------------------------------------------------------------
module swsh_power (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 advance,
    input  logic                                 valid_in,
    input  swsh_pkg::swsh_bin_t                  bin_in,
    input  logic [swsh_pkg::POW_W-1:0]           sigma_in,
    output logic                                 valid_out,
    output swsh_pkg::swsh_bin_t                  bin_out,
    output swsh_pkg::swsh_div_t                  div_out
);

    logic signed [2*swsh_pkg::COMP_W-1:0] sq_re_full;
    logic signed [2*swsh_pkg::COMP_W-1:0] sq_im_full;
    logic [swsh_pkg::SQ_W-1:0]            sq_re_reg;
    logic [swsh_pkg::SQ_W-1:0]            sq_im_reg;
    logic [swsh_pkg::POW_W-1:0]           sigma1_reg;
    swsh_pkg::swsh_bin_t                  bin1_reg;
    logic                                 v1_reg;

    logic [swsh_pkg::POW_W-1:0]           power_next;
    logic [swsh_pkg::POW_W-1:0]           power_reg;
    logic [swsh_pkg::POW_W-1:0]           sigma2_reg;
    swsh_pkg::swsh_bin_t                  bin2_reg;
    logic                                 v2_reg;

    logic [swsh_pkg::POW_W:0]             sub;
    logic                                 above;
    logic                                 full_gain;
    swsh_pkg::swsh_div_t                  div_next;
    swsh_pkg::swsh_div_t                  div_reg;
    swsh_pkg::swsh_bin_t                  bin3_reg;
    logic                                 v3_reg;

    assign sq_re_full = bin_in.re * bin_in.re;
    assign sq_im_full = bin_in.im * bin_in.im;
    assign power_next = {1'b0, sq_re_reg} + {1'b0, sq_im_reg};

    // Gain is one exactly when there is signal and no noise; otherwise seed
    // the remainder with power - sigma, or zero when noise swamps the bin.
    always_comb
    begin
        sub       = {1'b0, power_reg} - {1'b0, sigma2_reg};
        above     = !sub[swsh_pkg::POW_W] && (sub[swsh_pkg::POW_W-1:0] != '0);
        full_gain = (sigma2_reg == '0) && (power_reg != '0);
        div_next.rem     = (above && !full_gain) ? sub[swsh_pkg::POW_W-1:0] : '0;
        div_next.divisor = (power_reg == '0) ? swsh_pkg::POW_W'(1) : power_reg;
        div_next.quot    = {{(swsh_pkg::GAIN_W-1){1'b0}}, full_gain};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sq_re_reg  <= sq_re_full[swsh_pkg::SQ_W-1:0];
            sq_im_reg  <= sq_im_full[swsh_pkg::SQ_W-1:0];
            sigma1_reg <= sigma_in;
            bin1_reg   <= bin_in;
            power_reg  <= power_next;
            sigma2_reg <= sigma1_reg;
            bin2_reg   <= bin1_reg;
            div_reg    <= div_next;
            bin3_reg   <= bin2_reg;
        end
    end

    assign valid_out = v3_reg;
    assign bin_out   = bin3_reg;
    assign div_out   = div_reg;

endmodule

### hw/rtl/swsh_div_step.sv
// ----------------------------------------------------------------------------
// swsh_div_step
// One registered step of the restoring divider: shift, compare, subtract.
// ----------------------------------------------------------------------------
module swsh_div_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                valid_in,
    input  swsh_pkg::swsh_bin_t bin_in,
    input  swsh_pkg::swsh_div_t div_in,
    output logic                valid_out,
    output swsh_pkg::swsh_bin_t bin_out,
    output swsh_pkg::swsh_div_t div_out
);

    logic [swsh_pkg::POW_W:0] trial;
    logic                     fits;
    swsh_pkg::swsh_div_t      div_next;
    swsh_pkg::swsh_div_t      div_reg;
    swsh_pkg::swsh_bin_t      bin_reg;
    logic                     valid_reg;

    // Remainder stays below the divisor, so the doubled value fits one extra bit.
    always_comb
    begin
        trial = {div_in.rem, 1'b0};
        fits  = trial >= {1'b0, div_in.divisor};
        div_next.rem     = fits ? (trial[swsh_pkg::POW_W-1:0] - div_in.divisor)
                                : trial[swsh_pkg::POW_W-1:0];
        div_next.divisor = div_in.divisor;
        div_next.quot    = {div_in.quot[swsh_pkg::GAIN_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            div_reg <= div_next;
            bin_reg <= bin_in;
        end
    end

    assign valid_out = valid_reg;
    assign bin_out   = bin_reg;
    assign div_out   = div_reg;

endmodule

### hw/rtl/swsh_scale.sv
// ----------------------------------------------------------------------------
// swsh_scale
// Apply the Q16 gain to both components and hold the result item.
// ----------------------------------------------------------------------------
module swsh_scale (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               advance,
    input  logic                               valid_in,
    input  swsh_pkg::swsh_bin_t                bin_in,
    input  logic [swsh_pkg::GAIN_W-1:0]        gain_in,
    output logic                               valid_out,
    output logic signed [swsh_pkg::COMP_W-1:0] out_re,
    output logic signed [swsh_pkg::COMP_W-1:0] out_im,
    output logic [swsh_pkg::GAIN_W-1:0]        out_gain,
    output logic                               out_lst
);

    localparam int PROD_W = swsh_pkg::COMP_W + swsh_pkg::GAIN_W + 1;

    logic signed [swsh_pkg::GAIN_W:0]   gain_s;
    logic signed [PROD_W-1:0]           prod_re;
    logic signed [PROD_W-1:0]           prod_im;
    logic signed [swsh_pkg::COMP_W-1:0] re_reg;
    logic signed [swsh_pkg::COMP_W-1:0] im_reg;
    logic [swsh_pkg::GAIN_W-1:0]        gain_reg;
    logic                               last_reg;
    logic                               valid_reg;

    // Arithmetic shift by 16 of the signed product floors toward minus infinity.
    assign gain_s  = $signed({1'b0, gain_in});
    assign prod_re = bin_in.re * gain_s;
    assign prod_im = bin_in.im * gain_s;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            re_reg   <= prod_re[swsh_pkg::FRAC_W +: swsh_pkg::COMP_W];
            im_reg   <= prod_im[swsh_pkg::FRAC_W +: swsh_pkg::COMP_W];
            gain_reg <= gain_in;
            last_reg <= bin_in.last;
        end
    end

    assign valid_out = valid_reg;
    assign out_re    = re_reg;
    assign out_im    = im_reg;
    assign out_gain  = gain_reg;
    assign out_lst   = last_reg;

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for spectral_wiener_shrink. Drives complex bins with
// noise thresholds through the valid/stall input channel, predicts the Q16
// Wiener gain and the scaled components of each accepted bin, and compares
// every returned item field by field against the oldest prediction. Both
// channels idle at random per item, with stretches at full rate.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int IDLE_MAX   = 6;
    localparam int DRAIN_WAIT = 40;    // pipeline depth is 20
    localparam int STUCK_MAX  = 2000;  // cycles with no item moved on either side

    // One predicted result item.
    typedef struct {
        logic signed [swsh_pkg::COMP_W-1:0] re_o;
        logic signed [swsh_pkg::COMP_W-1:0] im_o;
        logic [swsh_pkg::GAIN_W-1:0]        gain;
        logic                               last;
    } shrunk_bin_t;

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_stall;
    logic signed [swsh_pkg::COMP_W-1:0] real_part;
    logic signed [swsh_pkg::COMP_W-1:0] imag_part;
    logic [swsh_pkg::POW_W-1:0]         noise_power;
    logic                               last_bin;
    logic                               out_valid;
    logic                               out_stall;
    logic signed [swsh_pkg::COMP_W-1:0] out_real;
    logic signed [swsh_pkg::COMP_W-1:0] out_imag;
    logic [swsh_pkg::GAIN_W-1:0]        shrink_gain;
    logic                               out_last;

    // Predicted results still owed by the block, oldest first.
    shrunk_bin_t pending_bins[$];
    int          mismatch_count;
    int          stuck_cycles;
    // Per-side switches for random idling; off gives full-rate stretches.
    bit          tx_idle_on;
    bit          rx_idle_on;

    spectral_wiener_shrink DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .real_part   (real_part),
        .imag_part   (imag_part),
        .noise_power (noise_power),
        .last_bin    (last_bin),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_real    (out_real),
        .out_imag    (out_imag),
        .shrink_gain (shrink_gain),
        .out_last    (out_last)
    );

    // 2 ns period.
    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Gain and scaling prediction.
    // power = re^2 + im^2 fits in 32 bits (at most 2^31). The gain is the
    // truncated quotient (power - noise) * 2^16 / power, zero when the power
    // is zero or the noise reaches it. Each component times the gain is
    // shifted right arithmetically, so negative products round toward minus
    // infinity.
    // ------------------------------------------------------------------------
    function automatic shrunk_bin_t wiener_shrink_predict(
        input logic signed [swsh_pkg::COMP_W-1:0] re,
        input logic signed [swsh_pkg::COMP_W-1:0] im,
        input logic [swsh_pkg::POW_W-1:0]         noise,
        input logic                               last
    );
        shrunk_bin_t       res;
        longint            re_l;
        longint            im_l;
        longint            gain_l;
        longint            scaled;
        longint unsigned   power;
        longint unsigned   noise_l;
        longint unsigned   quot;

        re_l    = re;
        im_l    = im;
        noise_l = noise;
        power   = re_l * re_l + im_l * im_l;
        quot    = 0;
        if (power != 0 && power > noise_l)
        begin
            quot = ((power - noise_l) << swsh_pkg::FRAC_W) / power;
            if (quot > (64'd1 << swsh_pkg::FRAC_W))
                quot = 64'd1 << swsh_pkg::FRAC_W;
        end
        gain_l   = quot;
        res.gain = quot[swsh_pkg::GAIN_W-1:0];
        scaled   = (re_l * gain_l) >>> swsh_pkg::FRAC_W;
        res.re_o = scaled[swsh_pkg::COMP_W-1:0];
        scaled   = (im_l * gain_l) >>> swsh_pkg::FRAC_W;
        res.im_o = scaled[swsh_pkg::COMP_W-1:0];
        res.last = last;
        return res;
    endfunction

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    // ------------------------------------------------------------------------
    // Input side. Called at a falling edge; returns at a falling edge with
    // in_valid still high, so back-to-back items keep valid asserted. The
    // prediction is queued at the rising edge that accepts the item.
    // ------------------------------------------------------------------------
    task automatic send_bin(
        input logic signed [swsh_pkg::COMP_W-1:0] re,
        input logic signed [swsh_pkg::COMP_W-1:0] im,
        input logic [swsh_pkg::POW_W-1:0]         noise,
        input logic                               last
    );
        int gap;

        gap = tx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        real_part   = re;
        imag_part   = im;
        noise_power = noise;
        last_bin    = last;
        in_valid    = 1'b1;
        // Hold the payload until the block takes it.
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        pending_bins.push_back(wiener_shrink_predict(re, im, noise, last));
        @(negedge clk);
    endtask

    // Draw a component: mostly full range, with small magnitudes and the
    // extremes mixed in.
    function automatic logic signed [swsh_pkg::COMP_W-1:0] pick_component();
        logic signed [swsh_pkg::COMP_W-1:0] val;

        case ($urandom_range(0, 9))
            0, 1:    val = swsh_pkg::COMP_W'($signed($urandom_range(0, 16)) - 8);
            2:
            begin
                case ($urandom_range(0, 3))
                    0:       val = 16'sh8000;
                    1:       val = 16'sh7FFF;
                    2:       val = 16'sh0000;
                    default: val = 16'shFFFF;
                endcase
            end
            default: val = swsh_pkg::COMP_W'($urandom);
        endcase
        return val;
    endfunction

    // One random bin, with the noise shaped around the bin's own power so
    // that most items land on a real gain rather than on zero.
    task automatic send_random_bin();
        logic signed [swsh_pkg::COMP_W-1:0] re;
        logic signed [swsh_pkg::COMP_W-1:0] im;
        logic [swsh_pkg::POW_W-1:0]         noise;
        longint                             re_l;
        longint                             im_l;
        longint unsigned                    power;

        re    = pick_component();
        im    = pick_component();
        re_l  = re;
        im_l  = im;
        power = re_l * re_l + im_l * im_l;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: noise = swsh_pkg::POW_W'((power * $urandom_range(0, 65535)) >> 16);
            4:          noise = swsh_pkg::POW_W'(power + $urandom_range(0, 4) - 2);
            5:          noise = 32'd0;
            6:          noise = $urandom_range(0, 255);
            7:          noise = $urandom;
            8:          noise = swsh_pkg::POW_W'(power - (power >> $urandom_range(1, 20)));
            default:    noise = swsh_pkg::POW_W'((power * $urandom_range(0, 65535)) >> 16);
        endcase
        send_bin(re, im, noise, 1'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // Output side: stall for a drawn number of cycles, then take one item.
    // ------------------------------------------------------------------------
    initial
    begin
        int hold;

        out_stall = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            hold = rx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
            if (hold > 0)
            begin
                out_stall = 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall = 1'b0;
            forever
            begin
                @(posedge clk);
                if (out_valid)
                    break;
            end
            @(negedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Result check: compare each returned item with the oldest prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        shrunk_bin_t want;

        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_bins.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result item: re %0d im %0d gain %0d",
                                          out_real, out_imag, shrink_gain));
            end
            else
            begin
                want = pending_bins.pop_front();
                if (out_real !== want.re_o)
                    report_mismatch($sformatf("out_real: got %0d, expected %0d",
                                              out_real, want.re_o));
                if (out_imag !== want.im_o)
                    report_mismatch($sformatf("out_imag: got %0d, expected %0d",
                                              out_imag, want.im_o));
                if (shrink_gain !== want.gain)
                    report_mismatch($sformatf("shrink_gain: got %0d, expected %0d",
                                              shrink_gain, want.gain));
                if (out_last !== want.last)
                    report_mismatch($sformatf("out_last: got %0d, expected %0d",
                                              out_last, want.last));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no item moves on either channel for too long.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_MAX)
            begin
                $display("[%0t] watchdog expired with %0d items outstanding",
                         $time, pending_bins.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Corner bins: zero power, noise at, just below and above the power,
    // full-scale components, unity gain, and negative rounding.
    task automatic test_corner_bins();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        send_bin(16'sd0, 16'sd0, 32'd0, 1'b0);                  // zero power
        send_bin(16'sd0, 16'sd0, 32'hFFFF_FFFF, 1'b1);
        send_bin(-16'sd32768, -16'sd32768, 32'd0, 1'b0);        // 2^31, unity gain
        send_bin(-16'sd32768, -16'sd32768, 32'h8000_0000, 1'b1); // noise equals power
        send_bin(-16'sd32768, -16'sd32768, 32'h7FFF_FFFF, 1'b0); // noise one below power, gain floors to zero
        send_bin(-16'sd32768, 16'sd32767, 32'h4000_0000, 1'b0);
        send_bin(16'sd32767, 16'sd32767, 32'd0, 1'b1);
        send_bin(16'sd32767, -16'sd32768, 32'd1, 1'b0);
        send_bin(16'sd1, 16'sd0, 32'd0, 1'b0);                  // unity on one LSB
        send_bin(16'sd1, 16'sd0, 32'd1, 1'b1);                  // noise equals power
        send_bin(-16'sd1, 16'sd0, 32'd0, 1'b0);
        send_bin(-16'sd1, -16'sd1, 32'd1, 1'b0);                // half gain, floor to -1
        send_bin(16'sd1, 16'sd1, 32'd1, 1'b1);                  // half gain, floor to 0
        send_bin(16'sd0, -16'sd32768, 32'h3FFF_FFFF, 1'b0);
        send_bin(16'sd100, 16'sd0, 32'h8000_0000, 1'b0);        // noise at top of range
        send_bin(16'sd32767, 16'sd32767, 32'hFFFF_FFFF, 1'b1);  // noise above range
        send_bin(16'sd12345, -16'sd23456, 32'd351_331_448, 1'b0);
        send_bin(-16'sd300, 16'sd400, 32'd249_999, 1'b1);
        send_bin(16'sd3, -16'sd4, 32'd24, 1'b0);
        send_bin(-16'sd32768, 16'sd0, 32'd1, 1'b1);
    endtask

    // Random bins with both sides idling.
    task automatic test_random_bins();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (500) send_random_bin();
    endtask

    // Full rate on both sides.
    task automatic test_streaming();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (200) send_random_bin();
    endtask

    // Steady input against an output that stalls.
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        repeat (100) send_random_bin();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        real_part      = '0;
        imag_part      = '0;
        noise_power    = '0;
        last_bin       = 1'b0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        mismatch_count = 0;
        stuck_cycles   = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_corner_bins();
        test_random_bins();
        test_streaming();
        test_backpressure();

        // Drop valid, let the pipeline drain, then watch for stray items.
        in_valid = 1'b0;
        while (pending_bins.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
